// ===== rtl/tpp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Three-point parabola peak: shared constants and types
// Field widths, internal arithmetic widths and the record that travels
// beside the divider pipeline.
// ----------------------------------------------------------------------------
package tpp_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int SAMPLE_BITS   = 16;

  // Port widths fixed by the interface.
  localparam int IN_W  = 16;
  localparam int XW    = 16;
  localparam int W_C0  = 50;
  localparam int W_C1  = 34;
  localparam int W_C2  = 18;
  localparam int W_EXT = 39;

  // The divisor is 8*|d|, a left shift by three.
  localparam int DIV_SHIFT = 3;

  // Internal arithmetic widths.
  localparam int DW     = SAMPLE_BITS + 2;        // second difference
  localparam int DFW    = SAMPLE_BITS + 1;        // y2 - y0
  localparam int MW     = DW + XW + 1;            // d * (2s+1), d * (s+1)
  localparam int TW     = MW + 1;                 // 2c1 and its helper term
  localparam int PW     = XW + TW;                // s * helper term
  localparam int C0W    = PW + 1;                 // full-width 2c0
  localparam int DVW    = SAMPLE_BITS + 1 + DIV_SHIFT;
  localparam int SQW    = 2 * SAMPLE_BITS;        // (y2 - y0)^2
  localparam int QW     = SQW + FRACTION_BITS;    // dividend and quotient
  localparam int EXT_CW = QW + 2;                 // extremum before wrapping

  typedef logic        [SAMPLE_BITS-1:0] samp_t;
  typedef logic signed [DW-1:0]          d_t;
  typedef logic signed [DFW-1:0]         df_t;
  typedef logic signed [MW-1:0]          m_t;
  typedef logic signed [TW-1:0]          tw_t;
  typedef logic signed [PW-1:0]          p_t;
  typedef logic signed [C0W-1:0]         c0w_t;
  typedef logic        [SQW-1:0]         sq_t;
  typedef logic        [DVW-1:0]         dv_t;
  typedef logic        [QW-1:0]          num_t;
  typedef logic signed [EXT_CW-1:0]      extc_t;
  typedef logic signed [W_C0-1:0]        c0_t;
  typedef logic signed [W_C1-1:0]        c1_t;
  typedef logic signed [W_C2-1:0]        c2_t;
  typedef logic signed [W_EXT-1:0]       ext_t;

  // Finished coefficients and what the extremum still needs after division.
  typedef struct packed {
    c0_t   c0;
    c1_t   c1;
    c2_t   c2;
    samp_t y1;
    logic  neg;
    logic  degen;
  } side_t;

endpackage
`default_nettype wire

// ===== rtl/tpp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Unsigned dividend over divisor, one quotient bit per stage, with a side
// record carried in step with each item. All stages advance together on en.
// ----------------------------------------------------------------------------
module tpp_div (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire tpp_pkg::num_t  in_num,
  input  wire tpp_pkg::dv_t   in_dv,
  input  wire tpp_pkg::side_t in_side,
  output logic                out_valid,
  output tpp_pkg::num_t       out_quot,
  output tpp_pkg::side_t      out_side
);

  localparam int QW  = tpp_pkg::QW;
  localparam int DVW = tpp_pkg::DVW;

  // Each stage shifts the dividend left and shifts the new quotient bit in
  // at the bottom, so after the last stage num_r holds the quotient.
  logic [QW-1:0]       valid_r;
  tpp_pkg::num_t       num_r   [QW];
  tpp_pkg::dv_t        rem_r   [QW];
  tpp_pkg::dv_t        dv_r    [QW];
  tpp_pkg::side_t      side_r  [QW];

  logic [QW-1:0]       valid_src;
  tpp_pkg::num_t       num_src [QW];
  tpp_pkg::dv_t        rem_src [QW];
  tpp_pkg::dv_t        dv_src  [QW];
  tpp_pkg::side_t      side_src[QW];

  logic [DVW:0]        trial   [QW];
  logic [QW-1:0]       ge;
  tpp_pkg::num_t       num_nxt [QW];
  tpp_pkg::dv_t        rem_nxt [QW];

  always_comb begin
    valid_src[0] = in_valid;
    num_src[0]   = in_num;
    rem_src[0]   = '0;
    dv_src[0]    = in_dv;
    side_src[0]  = in_side;
    for (int i = 1; i < QW; i++) begin
      valid_src[i] = valid_r[i-1];
      num_src[i]   = num_r[i-1];
      rem_src[i]   = rem_r[i-1];
      dv_src[i]    = dv_r[i-1];
      side_src[i]  = side_r[i-1];
    end
    for (int i = 0; i < QW; i++) begin
      trial[i]   = {rem_src[i], num_src[i][QW-1]};
      ge[i]      = (trial[i] >= {1'b0, dv_src[i]});
      rem_nxt[i] = ge[i] ? tpp_pkg::dv_t'(trial[i] - {1'b0, dv_src[i]})
                         : tpp_pkg::dv_t'(trial[i]);
      num_nxt[i] = {num_src[i][QW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= valid_src;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < QW; i++) begin
        num_r[i]  <= num_nxt[i];
        rem_r[i]  <= rem_nxt[i];
        dv_r[i]   <= dv_src[i];
        side_r[i] <= side_src[i];
      end
    end
  end

  assign out_valid = valid_r[QW-1];
  assign out_quot  = num_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule
`default_nettype wire

// ===== rtl/three_point_parabola_peak_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Three-point parabola peak
// Fits y = c0 + c1*x + c2*x^2 through samples at s, s+1, s+2 and returns the
// doubled coefficients and the vertex value in fixed point.
// ----------------------------------------------------------------------------
// The block takes one sample triplet per clock unless the pipeline holds,
// and returns one result per triplet, in order. Five register stages
// (operands, differences, products, linear coefficient, helper product)
// form the coefficients, the vertex division runs one quotient bit per
// stage through QW = 2*SAMPLE_BITS + FRACTION_BITS stages, and one output
// register follows. The pipeline holds while out_stall is high and a result
// waits at the output; a one-entry buffer at the input still takes one more
// transfer in that time, and in_stall then rises until the pipeline moves again.
module three_point_parabola_peak_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic signed [tpp_pkg::XW-1:0]    in_x_start,
  input  wire logic        [tpp_pkg::IN_W-1:0]  in_sample_first,
  input  wire logic        [tpp_pkg::IN_W-1:0]  in_sample_middle,
  input  wire logic        [tpp_pkg::IN_W-1:0]  in_sample_last,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [tpp_pkg::W_C0-1:0]       out_constant_coef_doubled,
  output logic signed [tpp_pkg::W_C1-1:0]       out_linear_coef_doubled,
  output logic signed [tpp_pkg::W_C2-1:0]       out_square_coef_doubled,
  output logic signed [tpp_pkg::W_EXT-1:0]      out_extremum_value,
  output logic                                  out_degenerate
);

  localparam int SB = tpp_pkg::SAMPLE_BITS;
  localparam int XW = tpp_pkg::XW;
  localparam int DW = tpp_pkg::DW;

  logic adv;

  // Input buffer.
  logic                   skid_valid_r, skid_valid_nxt;
  logic signed [XW-1:0]   skid_x_r;
  tpp_pkg::samp_t         skid_y0_r, skid_y1_r, skid_y2_r;

  logic                   src_valid;
  logic signed [XW-1:0]   src_x;
  tpp_pkg::samp_t         src_y0, src_y1, src_y2;

  // Stage 1: registered operands.
  logic                   s1_valid_r;
  logic signed [XW-1:0]   s1_x_r;
  tpp_pkg::samp_t         s1_y0_r, s1_y1_r, s1_y2_r;

  // Stage 2: differences.
  tpp_pkg::d_t            a0, a1, a2;
  tpp_pkg::d_t            d_nxt, dy_nxt;
  tpp_pkg::df_t           diff_nxt;
  logic                   s2_valid_r;
  tpp_pkg::d_t            s2_d_r, s2_dy_r;
  tpp_pkg::df_t           s2_diff_r;
  logic signed [XW-1:0]   s2_x_r;
  tpp_pkg::samp_t         s2_y0_r, s2_y1_r;

  // Stage 3: products.
  logic signed [XW:0]     x2p1, xp1;
  tpp_pkg::m_t            m1_nxt, m2_nxt;
  logic signed [2*tpp_pkg::DFW-1:0] dsq_full;
  logic                   s3_valid_r;
  tpp_pkg::m_t            s3_m1_r, s3_m2_r;
  tpp_pkg::sq_t           s3_dsq_r;
  tpp_pkg::d_t            s3_d_r, s3_dy_r;
  logic signed [XW-1:0]   s3_x_r;
  tpp_pkg::samp_t         s3_y0_r, s3_y1_r;

  // Stage 4: linear coefficient, helper term, divider operands.
  tpp_pkg::tw_t           c1_nxt, t_nxt;
  tpp_pkg::d_t            dabs;
  logic                   s4_valid_r;
  tpp_pkg::tw_t           s4_c1_r, s4_t_r;
  logic signed [XW-1:0]   s4_x_r;
  tpp_pkg::samp_t         s4_y0_r, s4_y1_r;
  tpp_pkg::d_t            s4_d_r;
  tpp_pkg::num_t          s4_num_r;
  tpp_pkg::dv_t           s4_dv_r;
  logic                   s4_neg_r, s4_degen_r;

  // Stage 5: s times helper term; 2c0 = 2*y0 - s*(2c1 + d*s).
  tpp_pkg::p_t            st_nxt;
  logic                   s5_valid_r;
  tpp_pkg::p_t            s5_st_r;
  tpp_pkg::tw_t           s5_c1_r;
  tpp_pkg::samp_t         s5_y0_r, s5_y1_r;
  tpp_pkg::d_t            s5_d_r;
  tpp_pkg::num_t          s5_num_r;
  tpp_pkg::dv_t           s5_dv_r;
  logic                   s5_neg_r, s5_degen_r;

  tpp_pkg::c0w_t          c0w;
  tpp_pkg::side_t         div_side_in;

  // Divider and output stage.
  logic                   div_valid;
  tpp_pkg::num_t          div_quot;
  tpp_pkg::side_t         div_side;
  tpp_pkg::extc_t         qx, qs, y1x, extw;
  tpp_pkg::ext_t          ext_nxt;
  logic                   out_valid_r;
  tpp_pkg::c0_t           out_c0_r;
  tpp_pkg::c1_t           out_c1_r;
  tpp_pkg::c2_t           out_c2_r;
  tpp_pkg::ext_t          out_ext_r;
  logic                   out_degen_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = skid_valid_r;

  // A transfer that arrives while the pipeline holds waits in the buffer.
  assign skid_valid_nxt = adv ? 1'b0 : (skid_valid_r || in_valid);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_valid_r <= 1'b0;
    end else begin
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && !skid_valid_r) begin
      skid_x_r  <= in_x_start;
      skid_y0_r <= in_sample_first[SB-1:0];
      skid_y1_r <= in_sample_middle[SB-1:0];
      skid_y2_r <= in_sample_last[SB-1:0];
    end
  end

  always_comb begin
    src_valid = skid_valid_r || in_valid;
    if (skid_valid_r) begin
      src_x  = skid_x_r;
      src_y0 = skid_y0_r;
      src_y1 = skid_y1_r;
      src_y2 = skid_y2_r;
    end else begin
      src_x  = in_x_start;
      src_y0 = in_sample_first[SB-1:0];
      src_y1 = in_sample_middle[SB-1:0];
      src_y2 = in_sample_last[SB-1:0];
    end
  end

  // Stage 2 logic.
  assign a0       = $signed({2'b00, s1_y0_r});
  assign a1       = $signed({2'b00, s1_y1_r});
  assign a2       = $signed({2'b00, s1_y2_r});
  assign d_nxt    = a0 - (a1 <<< 1) + a2;
  assign dy_nxt   = (a1 - a0) <<< 1;
  assign diff_nxt = $signed({1'b0, s1_y2_r}) - $signed({1'b0, s1_y0_r});

  // Stage 3 logic.
  assign x2p1     = $signed({s2_x_r, 1'b1});
  assign xp1      = $signed({s2_x_r[XW-1], s2_x_r}) + $signed({{XW{1'b0}}, 1'b1});
  assign m1_nxt   = s2_d_r * x2p1;
  assign m2_nxt   = s2_d_r * xp1;
  assign dsq_full = s2_diff_r * s2_diff_r;

  // Stage 4 logic.
  assign c1_nxt = tpp_pkg::tw_t'(s3_dy_r) - tpp_pkg::tw_t'(s3_m1_r);
  assign t_nxt  = tpp_pkg::tw_t'(s3_dy_r) - tpp_pkg::tw_t'(s3_m2_r);
  assign dabs   = s3_d_r[DW-1] ? -s3_d_r : s3_d_r;

  // Stage 5 logic.
  assign st_nxt = s4_x_r * s4_t_r;

  // Divider entry.
  assign c0w = tpp_pkg::c0w_t'($signed({2'b00, s5_y0_r, 1'b0}))
             - tpp_pkg::c0w_t'(s5_st_r);

  always_comb begin
    div_side_in.c0    = tpp_pkg::c0_t'(c0w);
    div_side_in.c1    = tpp_pkg::c1_t'(s5_c1_r);
    div_side_in.c2    = tpp_pkg::c2_t'(s5_d_r);
    div_side_in.y1    = s5_y1_r;
    div_side_in.neg   = s5_neg_r;
    div_side_in.degen = s5_degen_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
      s5_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= src_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
      s5_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_x_r     <= src_x;
      s1_y0_r    <= src_y0;
      s1_y1_r    <= src_y1;
      s1_y2_r    <= src_y2;

      s2_d_r     <= d_nxt;
      s2_dy_r    <= dy_nxt;
      s2_diff_r  <= diff_nxt;
      s2_x_r     <= s1_x_r;
      s2_y0_r    <= s1_y0_r;
      s2_y1_r    <= s1_y1_r;

      s3_m1_r    <= m1_nxt;
      s3_m2_r    <= m2_nxt;
      s3_dsq_r   <= dsq_full[tpp_pkg::SQW-1:0];
      s3_d_r     <= s2_d_r;
      s3_dy_r    <= s2_dy_r;
      s3_x_r     <= s2_x_r;
      s3_y0_r    <= s2_y0_r;
      s3_y1_r    <= s2_y1_r;

      s4_c1_r    <= c1_nxt;
      s4_t_r     <= t_nxt;
      s4_x_r     <= s3_x_r;
      s4_y0_r    <= s3_y0_r;
      s4_y1_r    <= s3_y1_r;
      s4_d_r     <= s3_d_r;
      s4_num_r   <= tpp_pkg::num_t'(s3_dsq_r) << tpp_pkg::FRACTION_BITS;
      s4_dv_r    <= {dabs[DW-2:0], {tpp_pkg::DIV_SHIFT{1'b0}}};
      s4_neg_r   <= s3_d_r[DW-1];
      s4_degen_r <= (s3_d_r == '0);

      s5_st_r    <= st_nxt;
      s5_c1_r    <= s4_c1_r;
      s5_y0_r    <= s4_y0_r;
      s5_y1_r    <= s4_y1_r;
      s5_d_r     <= s4_d_r;
      s5_num_r   <= s4_num_r;
      s5_dv_r    <= s4_dv_r;
      s5_neg_r   <= s4_neg_r;
      s5_degen_r <= s4_degen_r;
    end
  end

  tpp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (s5_valid_r),
    .in_num    (s5_num_r),
    .in_dv     (s5_dv_r),
    .in_side   (div_side_in),
    .out_valid (div_valid),
    .out_quot  (div_quot),
    .out_side  (div_side)
  );

  // The quotient is truncated toward zero, so its sign is applied afterwards.
  assign qx      = tpp_pkg::extc_t'($signed({1'b0, div_quot}));
  assign qs      = div_side.neg ? -qx : qx;
  assign y1x     = tpp_pkg::extc_t'($signed({1'b0, div_side.y1})) <<< tpp_pkg::FRACTION_BITS;
  assign extw    = y1x - qs;
  assign ext_nxt = div_side.degen ? '0 : tpp_pkg::ext_t'(extw);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_c0_r    <= div_side.c0;
      out_c1_r    <= div_side.c1;
      out_c2_r    <= div_side.c2;
      out_ext_r   <= ext_nxt;
      out_degen_r <= div_side.degen;
    end
  end

  assign out_valid                 = out_valid_r;
  assign out_constant_coef_doubled = out_c0_r;
  assign out_linear_coef_doubled   = out_c1_r;
  assign out_square_coef_doubled   = out_c2_r;
  assign out_extremum_value        = out_ext_r;
  assign out_degenerate            = out_degen_r;

endmodule
`default_nettype wire

// ===== bench/three_point_parabola_peak_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Three-point parabola peak: self-checking testbench
// Sends sample triplets through the core with bursty input and a patterned
// output stall, predicts the doubled coefficients and the vertex value for
// every transfer, and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module three_point_parabola_peak_core_tb;

  localparam int IDLE_LIMIT   = 2000;
  localparam int TAIL_CYCLES  = 60;
  localparam int RANDOM_ITEMS = 450;

  typedef struct {
    logic signed [tpp_pkg::XW-1:0]   x;
    logic        [tpp_pkg::IN_W-1:0] y0;
    logic        [tpp_pkg::IN_W-1:0] y1;
    logic        [tpp_pkg::IN_W-1:0] y2;
    bit                              drain_first;
  } triplet_t;

  typedef struct packed {
    tpp_pkg::c0_t  c0;
    tpp_pkg::c1_t  c1;
    tpp_pkg::c2_t  c2;
    tpp_pkg::ext_t ext;
    logic          degen;
  } fit_t;

  typedef enum int {STALL_NONE, STALL_HALF, STALL_PERIODIC, STALL_SPARSE} stall_mode_e;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_valid         = 1'b0;
  logic                             in_stall;
  logic signed [tpp_pkg::XW-1:0]    in_x_start       = '0;
  logic        [tpp_pkg::IN_W-1:0]  in_sample_first  = '0;
  logic        [tpp_pkg::IN_W-1:0]  in_sample_middle = '0;
  logic        [tpp_pkg::IN_W-1:0]  in_sample_last   = '0;
  logic                             out_valid;
  logic                             out_stall        = 1'b0;
  logic signed [tpp_pkg::W_C0-1:0]  out_constant_coef_doubled;
  logic signed [tpp_pkg::W_C1-1:0]  out_linear_coef_doubled;
  logic signed [tpp_pkg::W_C2-1:0]  out_square_coef_doubled;
  logic signed [tpp_pkg::W_EXT-1:0] out_extremum_value;
  logic                             out_degenerate;

  triplet_t    triplet_q[$];
  fit_t        fit_q[$];
  triplet_t    next_triplet;
  fit_t        want;
  int          total_triplets;
  int          accepted_count = 0;
  int          results_owed   = 0;
  int          idle_cycles    = 0;
  int          mismatch_count = 0;
  int          burst_left     = 0;
  int          gap_left       = 0;
  int          mode_left      = 0;
  stall_mode_e stall_mode     = STALL_NONE;

  three_point_parabola_peak_core uut (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .in_valid                  (in_valid),
    .in_stall                  (in_stall),
    .in_x_start                (in_x_start),
    .in_sample_first           (in_sample_first),
    .in_sample_middle          (in_sample_middle),
    .in_sample_last            (in_sample_last),
    .out_valid                 (out_valid),
    .out_stall                 (out_stall),
    .out_constant_coef_doubled (out_constant_coef_doubled),
    .out_linear_coef_doubled   (out_linear_coef_doubled),
    .out_square_coef_doubled   (out_square_coef_doubled),
    .out_extremum_value        (out_extremum_value),
    .out_degenerate            (out_degenerate)
  );

  always #5 clk = ~clk;

  // Exact fit in 64-bit arithmetic; every intermediate fits with 16-bit samples.
  function automatic fit_t fit_parabola(input logic signed [tpp_pkg::XW-1:0] x,
                                        input logic [tpp_pkg::IN_W-1:0] a,
                                        input logic [tpp_pkg::IN_W-1:0] b,
                                        input logic [tpp_pkg::IN_W-1:0] c);
    longint smask;
    longint s, y0, y1, y2;
    longint d, lin2, con2, diff, num, quot, ext;
    fit_t   r;
    smask = (longint'(1) <<< tpp_pkg::SAMPLE_BITS) - 1;
    s     = longint'(x);
    y0    = longint'(a) & smask;
    y1    = longint'(b) & smask;
    y2    = longint'(c) & smask;
    d     = y0 - 2 * y1 + y2;
    lin2  = 2 * (y1 - y0) - d * (2 * s + 1);
    con2  = 2 * y0 - lin2 * s - d * s * s;
    ext   = 0;
    if (d != 0) begin
      diff = y2 - y0;
      num  = (diff * diff) <<< tpp_pkg::FRACTION_BITS;
      // Signed division truncates toward zero, as the vertex rounding requires.
      quot = num / (8 * d);
      ext  = (y1 <<< tpp_pkg::FRACTION_BITS) - quot;
    end
    r.c0    = con2[tpp_pkg::W_C0-1:0];
    r.c1    = lin2[tpp_pkg::W_C1-1:0];
    r.c2    = d[tpp_pkg::W_C2-1:0];
    r.ext   = ext[tpp_pkg::W_EXT-1:0];
    r.degen = (d == 0);
    return r;
  endfunction

  task automatic check_field(input string name, input longint want_v, input longint got_v);
    if (want_v !== got_v) begin
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  task automatic add_triplet(input int x, input int a, input int b, input int c,
                             input bit drain);
    triplet_t t;
    t.x           = x[tpp_pkg::XW-1:0];
    t.y0          = a[tpp_pkg::IN_W-1:0];
    t.y1          = b[tpp_pkg::IN_W-1:0];
    t.y2          = c[tpp_pkg::IN_W-1:0];
    t.drain_first = drain;
    triplet_q.push_back(t);
  endtask

  function automatic int sample_edge();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return 65535;
      2: return 1;
      3: return 32768;
      default: return int'($urandom_range(0, 65535));
    endcase
  endfunction

  // Driver: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left = $urandom_range(1, 24);
      gap_left   = 0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (triplet_q.size() == 0 ||
                   (triplet_q[0].drain_first && (results_owed != 0 || in_valid))) begin
        // A draining triplet waits until the pipeline has emptied completely.
        in_valid <= 1'b0;
      end else begin
        next_triplet = triplet_q.pop_front();
        in_valid         <= 1'b1;
        in_x_start       <= next_triplet.x;
        in_sample_first  <= next_triplet.y0;
        in_sample_middle <= next_triplet.y1;
        in_sample_last   <= next_triplet.y2;
        burst_left = burst_left - 1;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Receiver: the stall pattern is chosen anew at random intervals.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      mode_left = 0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(20, 120);
      end else begin
        mode_left = mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_HALF:     out_stall <= ($urandom_range(0, 1) == 1);
        STALL_PERIODIC: out_stall <= ((mode_left % 7) < 3);
        default:        out_stall <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Monitor: results are checked before this edge's input transfer is predicted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (fit_q.size() == 0) begin
          mismatch_count++;
          $display("%0t ns: result transfer with no prediction waiting", $time);
        end else begin
          want = fit_q.pop_front();
          check_field("constant_coef_doubled", want.c0, out_constant_coef_doubled);
          check_field("linear_coef_doubled", want.c1, out_linear_coef_doubled);
          check_field("square_coef_doubled", want.c2, out_square_coef_doubled);
          check_field("extremum_value", want.ext, out_extremum_value);
          check_field("degenerate", longint'(want.degen), longint'(out_degenerate));
        end
      end
      if (in_valid && !in_stall)
        fit_q.push_back(fit_parabola(in_x_start, in_sample_first, in_sample_middle,
                                     in_sample_last));
      accepted_count <= accepted_count + ((in_valid && !in_stall) ? 1 : 0);
      results_owed   <= results_owed + ((in_valid && !in_stall) ? 1 : 0)
                                     - ((out_valid && !out_stall) ? 1 : 0);
      idle_cycles    <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ?
                        0 : idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles", $time, idle_cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int n, kind, x, a, b, c, m;

    // Flat, ramp and extreme-curvature triplets, mostly at the ends of the x range.
    add_triplet(0, 0, 0, 0, 1'b0);
    add_triplet(32767, 65535, 65535, 65535, 1'b0);
    add_triplet(-32768, 0, 65535, 0, 1'b0);
    add_triplet(32767, 65535, 0, 65535, 1'b0);
    add_triplet(-32768, 65535, 0, 65535, 1'b0);
    add_triplet(32767, 0, 65535, 0, 1'b0);
    add_triplet(-32768, 0, 0, 65535, 1'b0);
    add_triplet(32767, 65535, 0, 0, 1'b0);
    add_triplet(-32768, 0, 65535, 65535, 1'b0);
    add_triplet(-1, 0, 32767, 65534, 1'b0);
    add_triplet(1, 65535, 32768, 1, 1'b0);
    // Vertex quotients that are exact, and ones truncated on both signs.
    add_triplet(0, 0, 0, 3, 1'b0);
    add_triplet(1, 0, 2, 1, 1'b0);
    add_triplet(-1, 5, 0, 2, 1'b0);
    add_triplet(2, 1, 0, 0, 1'b0);
    add_triplet(-2, 7, 9, 4, 1'b0);
    // Alternating bit patterns.
    add_triplet(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b0);
    add_triplet(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0);
    add_triplet(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b0);
    add_triplet(16'h8001, 16'h0001, 16'hFFFE, 16'h0001, 1'b0);

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      kind = $urandom_range(0, 99);
      x    = $urandom_range(0, 65535);
      a    = $urandom_range(0, 65535);
      b    = $urandom_range(0, 65535);
      c    = $urandom_range(0, 65535);
      if (kind >= 40 && kind < 60) begin
        // Straight line through the middle sample: degenerate fit.
        m = (b < 65535 - b) ? b : 65535 - b;
        m = int'($urandom_range(0, 2 * m)) - m;
        a = b - m;
        c = b + m;
      end else if (kind >= 60 && kind < 75) begin
        // Nearly straight: second difference within four of zero where the last sample fits.
        m = 2 * b - a + int'($urandom_range(0, 8)) - 4;
        if (m >= 0 && m <= 65535)
          c = m;
      end else if (kind >= 75 && kind < 90) begin
        a = sample_edge();
        b = sample_edge();
        c = sample_edge();
        case ($urandom_range(0, 4))
          0: x = -32768;
          1: x = 32767;
          2: x = 0;
          3: x = -1;
          default: ;
        endcase
      end else if (kind >= 90) begin
        x = int'($urandom_range(0, 8)) - 4;
      end
      add_triplet(x, a, b, c, (n == 0) || (n == RANDOM_ITEMS / 2));
    end
    total_triplets = triplet_q.size();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (accepted_count != total_triplets) @(posedge clk);
    while (fit_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && fit_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tpp_pkg.sv
rtl/tpp_div.sv
rtl/three_point_parabola_peak_core.sv
bench/three_point_parabola_peak_core_tb.sv
